### design/vnorm_pkg.sv
// shared types and constants for the four-component vector normalizer
// no dependencies
`timescale 1ns / 1ps

package vnorm_pkg;

  localparam int unsigned LANES = 4;

  // per-lane sideband carried alongside the arithmetic
  typedef struct packed {
    logic neg;
    logic zero;
  } vnorm_side_t;

endpackage

### design/vnorm_lane.sv
// one normalization lane: restoring divide of the scaled square by the sum,
// then digit-by-digit integer square root, one step per pipeline stage; uses vnorm_pkg
`timescale 1ns / 1ps

module vnorm_lane #(
  parameter int CW = 16,
  parameter int F  = 15
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [2*CW-2:0]              sq,
  input  logic [2*CW:0]                sum,
  input  vnorm_pkg::vnorm_side_t       side_i,
  output logic [F+1:0]                 root,
  output vnorm_pkg::vnorm_side_t       side_o
);

  localparam int SW  = 2*CW+1;  // sum width
  localparam int RDW = SW+1;    // divide remainder width
  localparam int QW  = 2*F+3;   // quotient width
  localparam int RW  = F+2;     // root width
  localparam int RMW = RW+3;    // sqrt remainder width

  logic [RDW-1:0]         drem_r [QW];
  logic [SW-1:0]          dsum_r [QW];
  logic [QW-1:0]          dquo_r [QW];
  vnorm_pkg::vnorm_side_t dside_r[QW];

  logic [RMW-1:0]         srem_r [RW];
  logic [RW-1:0]          sroot_r[RW];
  logic [2*RW-1:0]        sd_r   [RW];
  vnorm_pkg::vnorm_side_t sside_r[RW];

  for (genvar i = 0; i < QW; i++) begin : g_div
    logic [RDW-1:0] rin;
    logic [RDW-1:0] rem_nxt;
    logic [QW-1:0]  quo_nxt;
    logic           ge;
    logic [SW-1:0]  s_in;
    if (i == 0) begin : g_first
      assign rin     = RDW'(sq);
      assign s_in    = sum;
      assign quo_nxt = QW'(ge);
    end else begin : g_next
      assign rin     = {drem_r[i-1][RDW-2:0], 1'b0};
      assign s_in    = dsum_r[i-1];
      assign quo_nxt = {dquo_r[i-1][QW-2:0], ge};
    end
    assign ge      = (rin >= RDW'(s_in));
    assign rem_nxt = ge ? (rin - RDW'(s_in)) : rin;
    always_ff @(posedge clk) begin
      if (en) begin
        drem_r[i]  <= rem_nxt;
        dsum_r[i]  <= s_in;
        dquo_r[i]  <= quo_nxt;
        dside_r[i] <= (i == 0) ? side_i : dside_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    logic [RMW-1:0]  rem_prev;
    logic [RW-1:0]   root_prev;
    logic [2*RW-1:0] d_in;
    vnorm_pkg::vnorm_side_t s_in;
    logic [RMW-1:0]  rin;
    logic [RMW-1:0]  trial;
    logic            ge;
    if (j == 0) begin : g_first
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign d_in      = {1'b0, dquo_r[QW-1]};
      assign s_in      = dside_r[QW-1];
    end else begin : g_next
      assign rem_prev  = srem_r[j-1];
      assign root_prev = sroot_r[j-1];
      assign d_in      = sd_r[j-1];
      assign s_in      = sside_r[j-1];
    end
    // bring down the next pair of radicand bits
    assign rin   = {rem_prev[RMW-3:0], d_in[2*RW-1-2*j -: 2]};
    assign trial = {1'b0, root_prev, 2'b01};
    assign ge    = (rin >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        srem_r[j]  <= ge ? (rin - trial) : rin;
        sroot_r[j] <= {root_prev[RW-2:0], ge};
        sd_r[j]    <= d_in;
        sside_r[j] <= s_in;
      end
    end
  end

  assign root   = sroot_r[RW-1];
  assign side_o = sside_r[RW-1];

endmodule

### design/vec4_normalize_unit.sv
// top level of the four-component vector normalizer: squares, merged sum,
// four vnorm_lane instances and the rounding output stage; uses vnorm_pkg
`timescale 1ns / 1ps
//
// channel  | direction | word contents
// ---------+-----------+------------------------------------------------
// in_      | slave     | tdata: comp_x, comp_y, comp_z, comp_w
// out_     | master    | tdata: unit_x, unit_y, unit_z, unit_w; tuser: zero_length
//
// one word per cycle while the output is not stalled; the stages are the square, the sum,
// 2*OUT_FRAC_BITS+3 divide steps, OUT_FRAC_BITS+2 root steps and the output register
// the whole pipeline advances together; it holds while a result waits untaken
// rst_n is synchronous and clears only the valid pipe

module vec4_normalize_unit #(
  parameter int COMP_WIDTH    = 16,
  parameter int OUT_FRAC_BITS = 15
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // comp_x, comp_y, comp_z, comp_w
  input  logic [((4*COMP_WIDTH+7)/8)*8-1:0]        in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // unit_x, unit_y, unit_z, unit_w
  output logic [((4*(OUT_FRAC_BITS+1)+7)/8)*8-1:0] out_tdata,
  // zero_length
  output logic                 out_tuser
);

  localparam int CW   = COMP_WIDTH;
  localparam int F    = OUT_FRAC_BITS;
  localparam int N    = vnorm_pkg::LANES;
  localparam int SQW  = 2*CW-1;
  localparam int SW   = 2*CW+1;
  localparam int RW   = F+2;
  localparam int UW   = F+1;
  localparam int OW   = ((4*UW+7)/8)*8;
  localparam int LAT  = (2*F+3) + RW;
  localparam int PIPE = 2 + LAT;

  logic             en;
  logic [PIPE-1:0]  pv_r;
  logic             out_valid_r;

  logic [SQW-1:0]   sq_a_r  [N];
  vnorm_pkg::vnorm_side_t side_a_r[N];
  logic [SQW-1:0]   sq_b_r  [N];
  vnorm_pkg::vnorm_side_t side_b_r[N];
  logic [SW-1:0]    sum_b_r;
  logic [RW-1:0]    root    [N];
  vnorm_pkg::vnorm_side_t side_l[N];
  logic [UW-1:0]    unit_r  [N];
  logic             zero_r;
  logic             all_zero;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      pv_r        <= {pv_r[PIPE-2:0], in_tvalid};
      out_valid_r <= pv_r[PIPE-1];
    end
  end

  always_comb begin
    all_zero = 1'b1;
    for (int k = 0; k < N; k++) begin
      if (in_tdata[k*CW +: CW] != '0) all_zero = 1'b0;
    end
  end

  // per-lane magnitude and square
  for (genvar k = 0; k < N; k++) begin : g_sq
    logic [CW-1:0]   c;
    logic [CW-1:0]   mag;
    logic [2*CW-1:0] prod;
    assign c    = in_tdata[k*CW +: CW];
    assign mag  = c[CW-1] ? (~c + CW'(1)) : c;
    assign prod = mag * mag;
    always_ff @(posedge clk) begin
      if (en) begin
        sq_a_r[k]        <= prod[SQW-1:0];
        side_a_r[k].neg  <= c[CW-1];
        side_a_r[k].zero <= all_zero;
      end
    end
  end

  // merge the four squares into the length squared
  always_ff @(posedge clk) begin
    if (en) begin
      sum_b_r <= SW'(sq_a_r[0]) + SW'(sq_a_r[1]) + SW'(sq_a_r[2]) + SW'(sq_a_r[3]);
      for (int k = 0; k < N; k++) begin
        sq_b_r[k]   <= sq_a_r[k];
        side_b_r[k] <= side_a_r[k];
      end
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_lane
    logic [RW-1:0] half;
    logic [UW-1:0] mag_s;
    vnorm_lane #(.CW(CW), .F(F)) u_lane (
      .clk    (clk),
      .en     (en),
      .sq     (sq_b_r[k]),
      .sum    (sum_b_r),
      .side_i (side_b_r[k]),
      .root   (root[k]),
      .side_o (side_l[k])
    );
    // root is floor(2q): round half up, then clamp below +1.0
    assign half  = RW'((root[k] + RW'(1)) >> 1);
    assign mag_s = half[F] ? UW'((1 << F) - 1) : UW'(half);
    always_ff @(posedge clk) begin
      if (en) begin
        unit_r[k] <= side_l[k].zero ? '0 : (side_l[k].neg ? (~mag_s + UW'(1)) : mag_s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) zero_r <= side_l[0].zero;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = zero_r;
  assign out_tdata  = OW'({unit_r[3], unit_r[2], unit_r[1], unit_r[0]});

`ifndef SYNTHESIS
  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("zero-length word carries nonzero components");

  a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (unit_r[0] != UW'(1 << F) && unit_r[1] != UW'(1 << F) &&
                    unit_r[2] != UW'(1 << F) && unit_r[3] != UW'(1 << F)))
    else $error("component magnitude exceeds saturation limit");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(pv_r))
    else $error("pipeline moved while output stalled");
`endif

endmodule
